@@ hw/rtl/tgarle_pkg.sv @@
// ----------------------------------------------------------------------------
// tgarle_pkg
// Shared types, constants and helpers of the Targa RLE pixel decoder.
// ----------------------------------------------------------------------------
package tgarle_pkg;

	// Palette size and index width
	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_IDX_W       = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	// Command queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Pixel depth modes
	localparam logic [1:0] MODE_PAL8  = 2'd0;
	localparam logic [1:0] MODE_555   = 2'd1;
	localparam logic [1:0] MODE_BGR24 = 2'd2;
	localparam logic [1:0] MODE_BGRA  = 2'd3;
	localparam logic [1:0] MODE_RESET = MODE_BGR24;

	// Stream byte constants
	localparam logic [7:0] HDR_RUN_BIT  = 8'h80;
	localparam logic [7:0] HDR_LEN_MASK = 8'h7f;
	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

	// Command from front to back.
	// Palette write: word = entry value, aux = palette index.
	// Pixel: word = {held bytes, last byte}, aux = repeat count.
	typedef struct packed {
		logic        pal_wr;
		logic [1:0]  mode;
		logic [31:0] word;
		logic [7:0]  aux;
	} cmd_t;

	// Grey ramp entry: blue = green = red = index, alpha opaque
	function automatic logic [31:0] grey_entry(input logic [7:0] idx);
		grey_entry = {ALPHA_OPAQUE, idx, idx, idx};
	endfunction

	// Index is inside the palette
	function automatic logic pal_in_range(input logic [7:0] idx);
		pal_in_range = ({1'b0, idx} < 9'(PALETTE_ENTRIES));
	endfunction

endpackage

@@ hw/rtl/tgarle_front.sv @@
// ----------------------------------------------------------------------------
// tgarle_front
// Packet parser: tracks headers, gathers pixel bytes and issues commands.
// ----------------------------------------------------------------------------
module tgarle_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               func,
	input  logic [7:0]         data_byte,
	input  logic               image_start,
	input  logic [7:0]         palette_index,
	input  logic [31:0]        palette_value,
	input  logic [1:0]         depth_mode,
	output logic               push,
	output tgarle_pkg::cmd_t   cmd
);

	logic        expect_hdr_q;
	logic        run_q;
	logic [7:0]  left_q;
	logic [1:0]  phase_q;
	logic [23:0] bytes_q;

	logic        eh_c, run_c;
	logic [7:0]  left_c;
	logic [1:0]  phase_c;
	logic [23:0] bytes_c;

	logic        eh_n, run_n;
	logic [7:0]  left_n;
	logic [1:0]  phase_n;
	logic [23:0] bytes_n;
	logic [2:0]  bpp;
	logic        emit;

	// Parser state with the image start clear applied first
	always_comb begin
		eh_c    = image_start | expect_hdr_q;
		run_c   = image_start ? 1'b0 : run_q;
		left_c  = image_start ? 8'd0 : left_q;
		phase_c = image_start ? 2'd0 : phase_q;
		bytes_c = image_start ? 24'd0 : bytes_q;
	end

	// Next state and command
	always_comb begin
		eh_n    = eh_c;
		run_n   = run_c;
		left_n  = left_c;
		phase_n = phase_c;
		bytes_n = bytes_c;
		bpp     = {1'b0, depth_mode} + 3'd1;
		emit    = 1'b0;
		cmd     = '0;
		cmd.mode = depth_mode;

		if (func) begin
			emit       = 1'b1;
			cmd.pal_wr = 1'b1;
			cmd.word   = palette_value;
			cmd.aux    = palette_index;
		end else if (eh_c) begin
			run_n   = |(data_byte & tgarle_pkg::HDR_RUN_BIT);
			left_n  = (data_byte & tgarle_pkg::HDR_LEN_MASK) + 8'd1;
			phase_n = 2'd0;
			bytes_n = 24'd0;
			eh_n    = 1'b0;
		end else if (({1'b0, phase_c} + 3'd1) < bpp) begin
			// Gather one more byte of the pixel
			case (phase_c)
				2'd0: bytes_n[7:0]   = data_byte;
				2'd1: bytes_n[15:8]  = data_byte;
				2'd2: bytes_n[23:16] = data_byte;
				default: bytes_n = bytes_c;
			endcase
			phase_n = phase_c + 2'd1;
		end else begin
			// Last byte of the pixel
			emit     = 1'b1;
			cmd.word = {bytes_c, data_byte};
			phase_n  = 2'd0;
			bytes_n  = 24'd0;
			if (run_c) begin
				cmd.aux = left_c;
				left_n  = 8'd0;
				eh_n    = 1'b1;
			end else begin
				cmd.aux = 8'd1;
				left_n  = left_c - 8'd1;
				if (left_n == 8'd0) begin
					eh_n = 1'b1;
				end
			end
		end
	end

	assign push = accept & emit;

	// Parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_hdr_q <= 1'b1;
			run_q        <= 1'b0;
			left_q       <= 8'd0;
			phase_q      <= 2'd0;
			bytes_q      <= 24'd0;
		end else if (accept) begin
			expect_hdr_q <= eh_n;
			run_q        <= run_n;
			left_q       <= left_n;
			phase_q      <= phase_n;
			bytes_q      <= bytes_n;
		end
	end

endmodule

@@ hw/rtl/tgarle_queue.sv @@
// ----------------------------------------------------------------------------
// tgarle_queue
// Short command FIFO between the parser and the pixel back end.
// ----------------------------------------------------------------------------
module tgarle_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tgarle_pkg::cmd_t   push_cmd,
	input  logic               pop,
	output tgarle_pkg::cmd_t   head_cmd,
	output logic               not_empty,
	output logic               full
);

	tgarle_pkg::cmd_t                 slot_q [tgarle_pkg::Q_DEPTH];
	logic [tgarle_pkg::Q_PTR_W-1:0]   wr_ptr_q;
	logic [tgarle_pkg::Q_PTR_W-1:0]   rd_ptr_q;
	logic [tgarle_pkg::Q_CNT_W-1:0]   count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == tgarle_pkg::Q_CNT_W'(tgarle_pkg::Q_DEPTH));
	assign head_cmd  = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/tgarle_back.sv @@
// ----------------------------------------------------------------------------
// tgarle_back
// Palette memory, pixel formatting and the output register.
// ----------------------------------------------------------------------------
module tgarle_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tgarle_pkg::cmd_t   head_cmd,
	input  logic               not_empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [39:0]        out_data
);

	localparam int IW = tgarle_pkg::PAL_IDX_W;

	logic [31:0] pal_mem [tgarle_pkg::PALETTE_ENTRIES];
	logic [tgarle_pkg::PALETTE_ENTRIES-1:0] written_q;

	logic        valid_s1;
	logic [1:0]  mode_s1;
	logic [31:0] word_s1;
	logic [7:0]  rep_s1;
	logic [31:0] rdata_s1;
	logic        hit_s1;

	logic        out_valid_q;
	logic [39:0] out_data_q;

	logic        out_free, s1_ready, head_in_range, rd_in_range;
	logic [IW-1:0] wr_addr, rd_addr;
	logic [31:0] entry;
	logic [7:0]  blue, green, red, alpha, lo;

	assign out_free      = ~out_valid_q | out_ready;
	assign s1_ready      = ~valid_s1 | out_free;
	assign pop           = not_empty & s1_ready;
	assign head_in_range = tgarle_pkg::pal_in_range(head_cmd.aux);
	assign rd_in_range   = tgarle_pkg::pal_in_range(head_cmd.word[7:0]);
	assign wr_addr       = head_cmd.aux[IW-1:0];
	assign rd_addr       = head_cmd.word[IW-1:0];

	// Palette memory: write on a popped write request, registered read
	always_ff @(posedge clk) begin
		if (pop && head_cmd.pal_wr && head_in_range) begin
			pal_mem[wr_addr] <= head_cmd.word;
		end
		if (pop) begin
			rdata_s1 <= pal_mem[rd_addr];
		end
	end

	// Written flags: an unwritten entry reads as the grey ramp
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (pop && head_cmd.pal_wr && head_in_range) begin
			written_q[wr_addr] <= 1'b1;
		end
	end

	// Stage 1 holds a pixel request while its palette read completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= pop & ~head_cmd.pal_wr;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mode_s1 <= head_cmd.mode;
			word_s1 <= head_cmd.word;
			rep_s1  <= head_cmd.aux;
			hit_s1  <= rd_in_range & written_q[rd_addr];
		end
	end

	// Pixel formatting
	always_comb begin
		entry = hit_s1 ? rdata_s1 : tgarle_pkg::grey_entry(word_s1[7:0]);
		lo    = word_s1[15:8];
		blue  = word_s1[15:8];
		green = word_s1[23:16];
		red   = word_s1[7:0];
		alpha = tgarle_pkg::ALPHA_OPAQUE;
		case (mode_s1)
			tgarle_pkg::MODE_PAL8: begin
				blue  = entry[7:0];
				green = entry[15:8];
				red   = entry[23:16];
				alpha = entry[31:24];
			end
			tgarle_pkg::MODE_555: begin
				blue  = {lo[4:0], 3'b000};
				green = {word_s1[1:0], lo[7:5], 3'b000};
				red   = {word_s1[6:2], 3'b000};
			end
			tgarle_pkg::MODE_BGR24: begin
				red = word_s1[7:0];
			end
			default: begin
				red   = word_s1[31:24];
				alpha = word_s1[7:0];
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			out_data_q <= {rep_s1, alpha, red, green, blue};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ hw/rtl/tga_rle_pixel_decoder.sv @@
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Targa RLE pixel stream decoder with palette, one byte per request.
//
//   Channel  Direction  Handshake          Payload
//   s_*      in         s_tvalid/s_tready  stream byte or palette write
//   m_*      out        m_tvalid/m_tready  BGRA pixel and repeat count
//   cfg_*    in         cfg_valid/cfg_ready pixel depth mode (2 bits)
//
// One input request per cycle while the queue is not full. m_tvalid rises after
// the edge that takes the last byte of a pixel: the command enters the queue at
// that edge, then palette read, then output register. The queue (four entries)
// lets the parser keep taking bytes while the output stalls; s_tready drops
// only when the queue is full.
// Reset sets depth mode to 24-bit BGR, clears the parser and makes the
// palette read as a grey ramp with alpha 255.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // data_byte[7:0], palette_index[15:8], palette_value[47:16]
	input  logic [1:0]  s_tuser,   // func[0], image_start[1]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // pixel_blue, pixel_green, pixel_red, pixel_alpha, repeat_count
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data   // pixel_depth_mode
);

	logic [1:0]       mode_q;
	logic             accept, push, pop, q_not_empty, q_full;
	tgarle_pkg::cmd_t push_cmd, head_cmd;

	assign cfg_ready = 1'b1;
	assign s_tready  = ~q_full;
	assign accept    = s_tvalid & s_tready;

	// Depth mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tgarle_pkg::MODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	tgarle_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.func          (s_tuser[0]),
		.data_byte     (s_tdata[7:0]),
		.image_start   (s_tuser[1]),
		.palette_index (s_tdata[15:8]),
		.palette_value (s_tdata[47:16]),
		.depth_mode    (mode_q),
		.push          (push),
		.cmd           (push_cmd)
	);

	tgarle_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.head_cmd  (head_cmd),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	tgarle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_cmd  (head_cmd),
		.not_empty (q_not_empty),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

@@ dv/tga_rle_pixel_decoder_test.sv @@
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder_test
// Self-checking bench for the Targa RLE pixel decoder. A driver feeds stream
// bytes, palette writes and depth mode writes from a planned queue. A shadow
// decoder predicts each pixel when its byte is accepted. A monitor compares
// every pixel result field by field. Both sides idle at random.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder_test;

	localparam logic FUNC_STREAM  = 1'b0;
	localparam logic FUNC_PALETTE = 1'b1;
	localparam int   SETTLE_CYCLES = 8;

	typedef enum logic [1:0] {ACT_BYTE, ACT_CFG, ACT_DRAIN} act_t;

	// One input request, fields as the block sees them
	typedef struct packed {
		logic        func;
		logic [7:0]  data_byte;
		logic        image_start;
		logic [7:0]  pal_idx;
		logic [31:0] pal_val;
	} stream_req_t;

	// Packed in m_tdata order: blue in the low byte
	typedef struct packed {
		logic [7:0] rep_count;
		logic [7:0] alpha;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct {
		act_t        act;
		stream_req_t req;
		logic [1:0]  mode;
	} plan_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // data_byte[7:0], palette_index[15:8], palette_value[47:16]
	logic [1:0]  s_tuser = '0;   // func[0], image_start[1]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // blue, green, red, alpha, repeat_count
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data = '0;

	plan_t  plan[$];
	pixel_t pending_pixels[$];
	int     fails = 0;
	int     n_items = 0;
	logic [1:0] gen_mode;
	string  field_name[5] = '{"pixel_blue", "pixel_green", "pixel_red", "pixel_alpha",
		"repeat_count"};

	// Shadow decoder state
	logic [1:0]  mode_shadow;
	logic        hdr_wait;
	logic        run_pkt;
	logic [7:0]  px_left;
	logic [1:0]  phase;
	logic [23:0] held_bytes;
	logic [31:0] pal_shadow[256];

	tga_rle_pixel_decoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow decoder
	// ------------------------------------------------------------------
	task automatic clear_parser();
		hdr_wait   = 1'b1;
		run_pkt    = 1'b0;
		px_left    = '0;
		phase      = '0;
		held_bytes = '0;
	endtask

	task automatic reset_shadow();
		mode_shadow = tgarle_pkg::MODE_RESET;
		clear_parser();
		for (int i = 0; i < 256; i++)
			pal_shadow[i] = {8'hff, 8'(i), 8'(i), 8'(i)};
	endtask

	// Advance the shadow by one accepted request, queue a pixel if one completes
	task automatic decode_byte(input stream_req_t r);
		pixel_t      px;
		logic [7:0]  b;
		logic [7:0]  lo;
		logic [31:0] e;
		b = r.data_byte;
		if (r.image_start)
			clear_parser();
		if (r.func == FUNC_PALETTE) begin
			if (int'(r.pal_idx) < tgarle_pkg::PALETTE_ENTRIES)
				pal_shadow[r.pal_idx] = r.pal_val;
			return;
		end
		if (hdr_wait) begin
			run_pkt    = b[7];
			px_left    = {1'b0, b[6:0]} + 8'd1;
			phase      = '0;
			held_bytes = '0;
			hdr_wait   = 1'b0;
			return;
		end
		// still gathering bytes of this pixel
		if (int'(phase) < int'(mode_shadow)) begin
			held_bytes[8*phase +: 8] = b;
			phase = phase + 2'd1;
			return;
		end
		lo = held_bytes[7:0];
		case (mode_shadow)
			tgarle_pkg::MODE_PAL8: begin
				e = (int'(b) < tgarle_pkg::PALETTE_ENTRIES) ? pal_shadow[b]
					: {8'hff, b, b, b};
				px.blue  = e[7:0];
				px.green = e[15:8];
				px.red   = e[23:16];
				px.alpha = e[31:24];
			end
			tgarle_pkg::MODE_555: begin
				px.blue  = {lo[4:0], 3'b000};
				px.green = {b[1:0], lo[7:5], 3'b000};
				px.red   = {b[6:2], 3'b000};
				px.alpha = 8'hff;
			end
			tgarle_pkg::MODE_BGR24: begin
				px.blue  = held_bytes[7:0];
				px.green = held_bytes[15:8];
				px.red   = b;
				px.alpha = 8'hff;
			end
			default: begin
				px.blue  = held_bytes[7:0];
				px.green = held_bytes[15:8];
				px.red   = held_bytes[23:16];
				px.alpha = b;
			end
		endcase
		phase      = '0;
		held_bytes = '0;
		if (run_pkt) begin
			px.rep_count = px_left;
			px_left      = '0;
			hdr_wait     = 1'b1;
		end else begin
			px.rep_count = 8'd1;
			px_left      = px_left - 8'd1;
			if (px_left == 8'd0)
				hdr_wait = 1'b1;
		end
		pending_pixels.push_back(px);
	endtask

	// ------------------------------------------------------------------
	// Stimulus planning
	// ------------------------------------------------------------------
	task automatic add_req(input logic func, input logic [7:0] b, input logic start,
			input logic [7:0] idx, input logic [31:0] val);
		plan_t p;
		p.act = ACT_BYTE;
		p.req = '{func: func, data_byte: b, image_start: start, pal_idx: idx, pal_val: val};
		p.mode = '0;
		plan.push_back(p);
		n_items++;
	endtask

	task automatic add_byte(input logic [7:0] b, input logic start);
		add_req(FUNC_STREAM, b, start, 8'($urandom), $urandom);
	endtask

	task automatic add_pal(input logic [7:0] idx, input logic [31:0] val, input logic start);
		add_req(FUNC_PALETTE, 8'($urandom), start, idx, val);
	endtask

	task automatic add_cfg(input logic [1:0] mode);
		plan_t p;
		p.act  = ACT_CFG;
		p.req  = '0;
		p.mode = mode;
		plan.push_back(p);
		gen_mode = mode;
	endtask

	task automatic add_drain();
		plan_t p;
		p.act  = ACT_DRAIN;
		p.req  = '0;
		p.mode = '0;
		plan.push_back(p);
	endtask

	// Well-formed packet with random content for the current depth
	task automatic add_packet(input logic start);
		logic       run;
		logic [6:0] len;
		int         npix;
		run = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 15))
			0:       len = 7'h7f;
			1:       len = 7'($urandom_range(0, 127));
			default: len = 7'($urandom_range(0, 7));
		endcase
		// keep long literals to the narrow depths
		if (!run && gen_mode >= tgarle_pkg::MODE_BGR24 && len > 7'd15)
			len = len & 7'h0f;
		add_byte((run ? tgarle_pkg::HDR_RUN_BIT : 8'h00) | {1'b0, len}, start);
		npix = run ? 1 : int'(len) + 1;
		for (int p = 0; p < npix; p++) begin
			if (gen_mode == tgarle_pkg::MODE_PAL8 && $urandom_range(0, 7) == 0)
				add_pal(8'($urandom), $urandom, 1'b0);
			for (int k = 0; k <= int'(gen_mode); k++)
				add_byte(8'($urandom), 1'b0);
		end
	endtask

	// Stray bytes, palette writes with image start, broken packets
	task automatic add_noise();
		case ($urandom_range(0, 2))
			0: repeat ($urandom_range(1, 4)) add_byte(8'($urandom), 1'b0);
			1: add_pal(8'($urandom), $urandom, 1'b1);
			default: begin
				add_byte(8'($urandom), 1'($urandom_range(0, 1)));
				add_byte(8'($urandom), 1'b0);
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Driver: stream requests and depth mode writes
	// ------------------------------------------------------------------
	plan_t cur;
	int    tx_gap = 0;
	int    settle = 0;
	logic  tx_burst = 1'b0;

	always @(posedge clk or negedge arst_n) begin : drv
		logic nxt_sv;
		logic nxt_cv;
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			nxt_sv = s_tvalid;
			nxt_cv = cfg_valid;
			// retire accepted requests
			if (s_tvalid && s_tready) begin
				decode_byte(cur.req);
				nxt_sv = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				mode_shadow = cur.mode;
				nxt_cv = 1'b0;
			end
			// launch the next planned action
			if (!nxt_sv && !nxt_cv) begin
				if (tx_gap > 0) begin
					tx_gap--;
				end else if (plan.size() > 0) begin
					case (plan[0].act)
						ACT_BYTE: begin
							cur = plan.pop_front();
							s_tdata <= {cur.req.pal_val, cur.req.pal_idx, cur.req.data_byte};
							s_tuser <= {cur.req.image_start, cur.req.func};
							nxt_sv = 1'b1;
							if ($urandom_range(0, 19) == 0)
								tx_burst = ~tx_burst;
							tx_gap = tx_burst ? 0 : $urandom_range(0, 3);
						end
						ACT_DRAIN: begin
							if (pending_pixels.size() == 0)
								void'(plan.pop_front());
						end
						default: begin
							// mode write only once the pipe has emptied
							if (pending_pixels.size() != 0) begin
								settle = 0;
							end else if (settle < SETTLE_CYCLES) begin
								settle++;
							end else begin
								settle = 0;
								cur = plan.pop_front();
								cfg_data <= cur.mode;
								nxt_cv = 1'b1;
							end
						end
					endcase
				end
			end
			s_tvalid  <= nxt_sv;
			cfg_valid <= nxt_cv;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: pixel results against the shadow decoder
	// ------------------------------------------------------------------
	int   rx_wait = 0;
	logic rx_burst = 1'b0;

	always @(posedge clk or negedge arst_n) begin : mon
		pixel_t want;
		logic   nxt_rdy;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			nxt_rdy = m_tready;
			if (m_tvalid && m_tready) begin
				if (pending_pixels.size() == 0) begin
					$error("pixel result with none expected: %h", m_tdata);
					fails++;
				end else begin
					want = pending_pixels.pop_front();
					for (int f = 0; f < 5; f++) begin
						if (m_tdata[8*f +: 8] !== want[8*f +: 8]) begin
							$error("%s: expected %0d, got %0d", field_name[f],
								want[8*f +: 8], m_tdata[8*f +: 8]);
							fails++;
						end
					end
				end
				if ($urandom_range(0, 19) == 0)
					rx_burst = ~rx_burst;
				rx_wait = rx_burst ? 0 : $urandom_range(0, 3);
				if (rx_wait > 0)
					nxt_rdy = 1'b0;
			end else if (!m_tready) begin
				if (rx_wait > 0)
					rx_wait--;
				if (rx_wait == 0)
					nxt_rdy = 1'b1;
			end
			m_tready <= nxt_rdy;
		end
	end

	// ------------------------------------------------------------------
	// Run control
	// ------------------------------------------------------------------
	initial begin
		logic [1:0] phase_mode[8];
		int         phase_end;
		logic       resync;
		phase_mode = '{tgarle_pkg::MODE_PAL8, tgarle_pkg::MODE_555, tgarle_pkg::MODE_BGRA,
			tgarle_pkg::MODE_BGR24, tgarle_pkg::MODE_PAL8, tgarle_pkg::MODE_BGRA,
			tgarle_pkg::MODE_555, tgarle_pkg::MODE_BGR24};
		reset_shadow();
		gen_mode = tgarle_pkg::MODE_RESET;

		// Directed: 24-bit run of 128 and a literal of 2
		add_byte(8'hff, 1'b1);
		add_byte(8'h00, 1'b0); add_byte(8'hff, 1'b0); add_byte(8'h5a, 1'b0);
		add_byte(8'h01, 1'b0);
		add_byte(8'hff, 1'b0); add_byte(8'hff, 1'b0); add_byte(8'hff, 1'b0);
		add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0); add_byte(8'h00, 1'b0);
		// 32-bit run of 1, then a pixel left half done across a depth change
		add_cfg(tgarle_pkg::MODE_BGRA);
		add_byte(8'h80, 1'b1);
		add_byte(8'h12, 1'b0); add_byte(8'h34, 1'b0); add_byte(8'h56, 1'b0);
		add_byte(8'hff, 1'b0);
		add_byte(8'h00, 1'b0);
		add_byte(8'ha5, 1'b0); add_byte(8'h3c, 1'b0);
		add_cfg(tgarle_pkg::MODE_555);
		add_byte(8'hff, 1'b0);
		// Paletted: extreme entries, image start on a write and mid-packet
		add_cfg(tgarle_pkg::MODE_PAL8);
		add_pal(8'h00, $urandom, 1'b1);
		add_pal(8'hff, $urandom, 1'b0);
		add_byte(8'h81, 1'b0); add_byte(8'h00, 1'b0);
		add_byte(8'h02, 1'b0); add_byte(8'hff, 1'b0);
		add_byte(8'h80, 1'b1); add_byte(8'h07, 1'b0);

		// Random phases, one depth each
		for (int ph = 0; ph < 8; ph++) begin
			add_cfg(phase_mode[ph]);
			phase_end = n_items + 215;
			resync = 1'b1;
			while (n_items < phase_end) begin
				if ($urandom_range(0, 9) == 0) begin
					add_noise();
					resync = 1'b1;
				end
				add_packet(resync || $urandom_range(0, 7) == 0);
				resync = 1'b0;
				if (ph == 2 && n_items > phase_end - 100 && n_items < phase_end - 60)
					add_drain();
			end
			// sometimes leave a pixel half gathered across the mode write
			if ($urandom_range(0, 1) == 0)
				repeat ($urandom_range(1, 3)) add_byte(8'($urandom), 1'b0);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (!(plan.size() == 0 && !s_tvalid && !cfg_valid && pending_pixels.size() == 0));
		repeat (10) @(posedge clk);

		if (fails == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ tga_rle_pixel_decoder.f @@
hw/rtl/tgarle_pkg.sv
hw/rtl/tgarle_front.sv
hw/rtl/tgarle_queue.sv
hw/rtl/tgarle_back.sv
hw/rtl/tga_rle_pixel_decoder.sv
dv/tga_rle_pixel_decoder_test.sv
